>>> rtl/scwl_pkg.sv
package scwl_pkg;

	localparam int VRAM_BYTES = 524288;
	localparam int CALL_DEPTH = 4;

	localparam int ADDR_W  = $clog2(VRAM_BYTES);
	localparam int WIDE_W  = ADDR_W + 20;
	localparam int DEPTH_W = $clog2(CALL_DEPTH + 1);
	localparam int IDX_W   = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
	localparam int OUT_AW  = 19;

	localparam int CMD_STRIDE = 32;

	localparam logic OP_START = 1'b0;
	localparam logic OP_CMD   = 1'b1;

	localparam logic [3:0] KIND_NORMAL    = 4'd0;
	localparam logic [3:0] KIND_SCALED    = 4'd1;
	localparam logic [3:0] KIND_DISTORTED = 4'd2;
	localparam logic [3:0] KIND_POLYGON   = 4'd3;
	localparam logic [3:0] KIND_POLYLINE  = 4'd4;
	localparam logic [3:0] KIND_LINE      = 4'd5;
	localparam logic [3:0] KIND_USER_CLIP = 4'd6;
	localparam logic [3:0] KIND_SYS_CLIP  = 4'd7;
	localparam logic [3:0] KIND_LOCAL     = 4'd8;
	localparam logic [3:0] KIND_INVALID   = 4'd9;

	localparam logic [2:0] JMP_NEXT    = 3'd0;
	localparam logic [2:0] JMP_ASSIGN  = 3'd1;
	localparam logic [2:0] JMP_CALL    = 3'd2;
	localparam logic [2:0] JMP_RETURN  = 3'd3;
	localparam logic [2:0] JMP_SKIP    = 3'd4;
	localparam logic [2:0] JMP_INVALID = 3'd5;

	localparam logic [2:0] CMODE_RGB     = 3'd5;
	localparam logic [2:0] CMODE_INVALID = 3'd6;

	localparam logic [15:0] CLIP_MAX_X = 16'd319;
	localparam logic [15:0] CLIP_MAX_Y = 16'd223;

	localparam logic [2:0] REG_START_OFFSET  = 3'd0;
	localparam logic [2:0] REG_COMMAND_LIMIT = 3'd4;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [15:0] rect_t [4];

	typedef struct packed {
		logic               operation;
		logic [15:0]        ctrl_word;
		logic [15:0]        link_word;
		logic [15:0]        mode_word;
		logic [15:0]        source_word;
		logic [15:0]        size_word;
		logic signed [15:0] vertex_a_x;
		logic signed [15:0] vertex_a_y;
		logic signed [15:0] vertex_c_x;
		logic signed [15:0] vertex_c_y;
		logic [15:0]        gouraud_word;
	} cmd_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [2:0] jump;
		logic       end_bit;
		logic [2:0] cmode;
		logic [2:0] calc;
		logic [3:0] flags;
		addr_t      char_addr;
		logic [8:0] width;
		logic [7:0] height;
		addr_t      gour_addr;
		addr_t      link_addr;
	} dec_t;

	typedef struct packed {
		logic [3:0]        command_kind;
		logic [2:0]        jump_kind;
		logic              end_flag;
		logic [2:0]        color_mode_code;
		logic [2:0]        color_calc;
		logic [3:0]        draw_flags;
		logic [OUT_AW-1:0] pattern_addr;
		logic [8:0]        pattern_width;
		logic [7:0]        pattern_height;
		logic [OUT_AW-1:0] shade_addr;
		logic [OUT_AW-1:0] next_offset;
		logic              walk_stop;
	} res_t;

	function automatic addr_t wrap_addr(input logic [WIDE_W-1:0] a);
		return a[ADDR_W-1:0];
	endfunction

	function automatic logic [OUT_AW-1:0] to_out(input addr_t a);
		logic [ADDR_W+OUT_AW-1:0] t;
		t = {{OUT_AW{1'b0}}, a};
		return t[OUT_AW-1:0];
	endfunction

	function automatic logic [3:0] kind_lookup(input logic [3:0] code);
		logic [3:0] k;
		unique case (code)
			4'd0:    k = KIND_NORMAL;
			4'd1:    k = KIND_SCALED;
			4'd2:    k = KIND_DISTORTED;
			4'd4:    k = KIND_POLYGON;
			4'd5:    k = KIND_POLYLINE;
			4'd6:    k = KIND_LINE;
			4'd8:    k = KIND_USER_CLIP;
			4'd9:    k = KIND_SYS_CLIP;
			4'd10:   k = KIND_LOCAL;
			default: k = KIND_INVALID;
		endcase
		return k;
	endfunction

endpackage

>>> rtl/scwl_decode.sv
module scwl_decode (
	input  scwl_pkg::cmd_t item,
	output scwl_pkg::dec_t dec
);
	import scwl_pkg::*;

	logic [2:0] jraw;
	logic [2:0] craw;

	assign jraw = item.ctrl_word[10:8];
	assign craw = item.mode_word[5:3];

	always_comb begin
		dec.kind      = kind_lookup(item.ctrl_word[3:0]);
		dec.jump      = (jraw > JMP_SKIP) ? JMP_INVALID : jraw;
		dec.end_bit   = item.ctrl_word[15];
		dec.cmode     = (craw > CMODE_RGB) ? CMODE_INVALID : craw;
		dec.calc      = item.mode_word[8:6];
		dec.flags     = {item.mode_word[7], item.mode_word[8],
			item.mode_word[10], item.mode_word[0]};
		dec.char_addr = wrap_addr(WIDE_W'({item.source_word, 3'b000}));
		dec.width     = {item.size_word[13:8], 3'b000};
		dec.height    = item.size_word[7:0];
		dec.gour_addr = wrap_addr(WIDE_W'({item.gouraud_word, 3'b000}));
		dec.link_addr = wrap_addr(WIDE_W'({item.link_word, 3'b000}));
	end

endmodule

>>> rtl/scwl_walker.sv
module scwl_walker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  scwl_pkg::cmd_t             item,
	input  scwl_pkg::dec_t             dec,
	input  logic [18:0]                walk_base,
	input  logic [15:0]                command_limit,
	output logic                       has_res,
	output scwl_pkg::res_t             res
);
	import scwl_pkg::*;

	addr_t               cur_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [15:0]         count_q;
	logic                active_q;
	addr_t               stack_q [CALL_DEPTH];
	rect_t               user_clip_q;
	rect_t               sys_clip_q;
	logic [15:0]         origin_x_q;
	logic [15:0]         origin_y_q;

	addr_t               nxt_cur;
	addr_t               nxt_pc;
	addr_t               succ;
	addr_t               skip_pc;
	logic [DEPTH_W-1:0]  nxt_depth;
	logic [DEPTH_W-1:0]  depth_dec;
	logic [15:0]         nxt_count;
	logic [15:0]         count_inc;
	logic                nxt_active;
	logic                oor;
	logic                push;
	logic                stop;
	logic                cap_user;
	logic                cap_sys;
	logic                cap_org;
	logic [IDX_W-1:0]    push_idx;
	logic [IDX_W-1:0]    pop_idx;

	assign succ      = wrap_addr(WIDE_W'(cur_q) + WIDE_W'(CMD_STRIDE));
	assign skip_pc   = wrap_addr(WIDE_W'(cur_q) + WIDE_W'(2 * CMD_STRIDE));
	assign oor       = (WIDE_W'(cur_q) + WIDE_W'(CMD_STRIDE)) > WIDE_W'(VRAM_BYTES);
	assign depth_dec = depth_q - 1'b1;
	assign push_idx  = depth_q[IDX_W-1:0];
	assign pop_idx   = depth_dec[IDX_W-1:0];
	assign count_inc = count_q + 16'd1;

	always_comb begin
		res        = '0;
		has_res    = 1'b0;
		nxt_cur    = cur_q;
		nxt_pc     = succ;
		nxt_depth  = depth_q;
		nxt_count  = count_q;
		nxt_active = active_q;
		push       = 1'b0;
		stop       = 1'b0;
		cap_user   = 1'b0;
		cap_sys    = 1'b0;
		cap_org    = 1'b0;
		if (item.operation == OP_START) begin
			nxt_cur    = wrap_addr(WIDE_W'(walk_base));
			nxt_depth  = '0;
			nxt_count  = '0;
			nxt_active = 1'b1;
		end else if (active_q) begin
			has_res = 1'b1;
			if (oor) begin
				res.command_kind = KIND_INVALID;
				res.next_offset  = to_out(cur_q);
				res.walk_stop    = 1'b1;
				nxt_active       = 1'b0;
			end else begin
				res.command_kind    = dec.kind;
				res.jump_kind       = dec.jump;
				res.end_flag        = dec.end_bit;
				res.color_mode_code = dec.cmode;
				res.color_calc      = dec.calc;
				res.draw_flags      = dec.flags;
				res.pattern_addr    = to_out(dec.char_addr);
				res.pattern_width   = dec.width;
				res.pattern_height  = dec.height;
				res.shade_addr      = to_out(dec.gour_addr);
				if (dec.kind == KIND_INVALID) begin
					res.next_offset = to_out(cur_q);
					res.walk_stop   = 1'b1;
					nxt_active      = 1'b0;
				end else begin
					cap_user  = (dec.kind == KIND_USER_CLIP);
					cap_sys   = (dec.kind == KIND_SYS_CLIP);
					cap_org   = (dec.kind == KIND_LOCAL);
					nxt_count = count_inc;
					if (dec.end_bit) begin
						res.next_offset = to_out(cur_q);
						res.walk_stop   = 1'b1;
						nxt_active      = 1'b0;
					end else begin
						case (dec.jump)
							JMP_ASSIGN: nxt_pc = dec.link_addr;
							JMP_CALL: begin
								if (depth_q < DEPTH_W'(CALL_DEPTH)) begin
									push      = 1'b1;
									nxt_depth = depth_q + 1'b1;
								end
								nxt_pc = dec.link_addr;
							end
							JMP_RETURN: begin
								if (depth_q != '0) begin
									nxt_depth = depth_dec;
									nxt_pc    = stack_q[pop_idx];
								end
							end
							JMP_SKIP: nxt_pc = skip_pc;
							default:  nxt_pc = succ;
						endcase
						stop            = count_inc >= command_limit;
						nxt_cur         = nxt_pc;
						res.next_offset = to_out(nxt_pc);
						res.walk_stop   = stop;
						nxt_active      = !stop;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			depth_q     <= '0;
			count_q     <= '0;
			active_q    <= 1'b0;
			user_clip_q <= '{16'd0, 16'd0, CLIP_MAX_X, CLIP_MAX_Y};
			sys_clip_q  <= '{16'd0, 16'd0, CLIP_MAX_X, CLIP_MAX_Y};
			origin_x_q  <= '0;
			origin_y_q  <= '0;
		end else if (fire) begin
			cur_q    <= nxt_cur;
			depth_q  <= nxt_depth;
			count_q  <= nxt_count;
			active_q <= nxt_active;
			if (cap_user) begin
				user_clip_q <= '{item.vertex_a_x, item.vertex_a_y,
					item.vertex_c_x, item.vertex_c_y};
			end
			if (cap_sys) begin
				sys_clip_q <= '{item.vertex_a_x, item.vertex_a_y,
					item.vertex_c_x, item.vertex_c_y};
			end
			if (cap_org) begin
				origin_x_q <= item.vertex_a_x;
				origin_y_q <= item.vertex_a_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && push) begin
			stack_q[push_idx] <= succ;
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(CALL_DEPTH))
		else $error("return stack depth over bound");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.operation == OP_START |=> active_q && depth_q == '0 && count_q == '0)
		else $error("start did not open a clean walk");

	a_stop_ends: assert property (@(posedge clk) disable iff (!arst_n)
		fire && has_res && res.walk_stop |=> !active_q)
		else $error("walk still active after stop");

	a_user_clip_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && cap_user) |=> $stable(user_clip_q[0]) && $stable(user_clip_q[2]))
		else $error("user clip changed without a clip command");

	a_sys_clip_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && cap_sys) |=> $stable(sys_clip_q[1]) && $stable(sys_clip_q[3]))
		else $error("system clip changed without a clip command");

	a_origin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && cap_org) |=> $stable(origin_x_q) && $stable(origin_y_q))
		else $error("local origin changed without a local command");

endmodule

>>> rtl/sprite_command_list_walker.sv
// Each input transaction passes an input register, then a result register.
// One item per cycle unless stalled; a start or a command outside a walk gives no result.
// Output stall backs up through a single input stage; in_stall rises only when both are full.
// Reset (arst_n low): no walk active, offset/depth/count zero, clips 0,0,319,223, origin zero,
// base offset 0, command_limit 65535. Return stack contents are not reset.
module sprite_command_list_walker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [15:0]        ctrl_word,
	input  logic [15:0]        link_word,
	input  logic [15:0]        mode_word,
	input  logic [15:0]        source_word,
	input  logic [15:0]        size_word,
	input  logic signed [15:0] vertex_a_x,
	input  logic signed [15:0] vertex_a_y,
	input  logic signed [15:0] vertex_c_x,
	input  logic signed [15:0] vertex_c_y,
	input  logic [15:0]        gouraud_word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         command_kind,
	output logic [2:0]         jump_kind,
	output logic               end_flag,
	output logic [2:0]         color_mode_code,
	output logic [2:0]         color_calc,
	output logic [3:0]         draw_flags,
	output logic [18:0]        pattern_addr,
	output logic [8:0]         pattern_width,
	output logic [7:0]         pattern_height,
	output logic [18:0]        shade_addr,
	output logic [18:0]        next_offset,
	output logic               walk_stop
);
	import scwl_pkg::*;

	logic [18:0] walk_base_q;
	logic [15:0] command_limit_q;
	logic        valid_s1;
	cmd_t        item_s1;
	logic        valid_s2;
	res_t        res_s2;
	dec_t        dec;
	res_t        res;
	logic        has_res;
	logic        advance;
	logic        fire;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_COMMAND_LIMIT[2]) ? {16'd0, command_limit_q}
		: {13'd0, walk_base_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_base_q     <= '0;
			command_limit_q <= 16'hFFFF;
		end else if (wr_en) begin
			if (paddr[2] == REG_COMMAND_LIMIT[2]) begin
				command_limit_q <= pwdata[15:0];
			end else begin
				walk_base_q <= pwdata[18:0];
			end
		end
	end

	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{operation, ctrl_word, link_word, mode_word, source_word,
				size_word, vertex_a_x, vertex_a_y, vertex_c_x, vertex_c_y, gouraud_word};
		end
	end

	scwl_decode u_decode (
		.item (item_s1),
		.dec  (dec)
	);

	scwl_walker u_walker (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.dec           (dec),
		.walk_base     (walk_base_q),
		.command_limit (command_limit_q),
		.has_res       (has_res),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_res) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign command_kind    = res_s2.command_kind;
	assign jump_kind       = res_s2.jump_kind;
	assign end_flag        = res_s2.end_flag;
	assign color_mode_code = res_s2.color_mode_code;
	assign color_calc      = res_s2.color_calc;
	assign draw_flags      = res_s2.draw_flags;
	assign pattern_addr    = res_s2.pattern_addr;
	assign pattern_width   = res_s2.pattern_width;
	assign pattern_height  = res_s2.pattern_height;
	assign shade_addr      = res_s2.shade_addr;
	assign next_offset     = res_s2.next_offset;
	assign walk_stop       = res_s2.walk_stop;

endmodule

>>> dv/tb_sprite_command_list_walker.sv
module tb_sprite_command_list_walker;
	timeunit 1ns;
	timeprecision 1ps;

	import scwl_pkg::*;

	localparam logic [3:0] CODE_NORMAL    = 4'd0;
	localparam logic [3:0] CODE_SCALED    = 4'd1;
	localparam logic [3:0] CODE_DISTORTED = 4'd2;
	localparam logic [3:0] CODE_BAD       = 4'd3;
	localparam logic [3:0] CODE_POLYGON   = 4'd4;
	localparam logic [3:0] CODE_POLYLINE  = 4'd5;
	localparam logic [3:0] CODE_LINE      = 4'd6;
	localparam logic [3:0] CODE_USER_CLIP = 4'd8;
	localparam logic [3:0] CODE_SYS_CLIP  = 4'd9;
	localparam logic [3:0] CODE_LOCAL     = 4'd10;
	localparam logic [3:0] CODE_BAD_TOP   = 4'd15;

	localparam logic [35:0] VALID_CODES = {CODE_LOCAL, CODE_SYS_CLIP, CODE_USER_CLIP, CODE_LINE,
		CODE_POLYLINE, CODE_POLYGON, CODE_DISTORTED, CODE_SCALED, CODE_NORMAL};

	// kind per 4-bit code, code 15 in the top nibble
	localparam logic [63:0] KIND_MAP = {KIND_INVALID, KIND_INVALID, KIND_INVALID, KIND_INVALID,
		KIND_INVALID, KIND_LOCAL, KIND_SYS_CLIP, KIND_USER_CLIP, KIND_INVALID, KIND_LINE,
		KIND_POLYLINE, KIND_POLYGON, KIND_INVALID, KIND_DISTORTED, KIND_SCALED, KIND_NORMAL};

	localparam logic [15:0] MODE_ECD     = 16'h0080;
	localparam logic [15:0] MODE_SPD     = 16'h0100;
	localparam logic [15:0] MODE_GOURAUD = 16'h0400;
	localparam logic [15:0] MODE_MESH    = 16'h0001;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	cmd_t        in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  command_kind;
	logic [2:0]  jump_kind;
	logic        end_flag;
	logic [2:0]  color_mode_code;
	logic [2:0]  color_calc;
	logic [3:0]  draw_flags;
	logic [18:0] pattern_addr;
	logic [8:0]  pattern_width;
	logic [7:0]  pattern_height;
	logic [18:0] shade_addr;
	logic [18:0] next_offset;
	logic        walk_stop;

	sprite_command_list_walker u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(in_item.operation), .ctrl_word(in_item.ctrl_word),
		.link_word(in_item.link_word), .mode_word(in_item.mode_word),
		.source_word(in_item.source_word), .size_word(in_item.size_word),
		.vertex_a_x(in_item.vertex_a_x), .vertex_a_y(in_item.vertex_a_y),
		.vertex_c_x(in_item.vertex_c_x), .vertex_c_y(in_item.vertex_c_y),
		.gouraud_word(in_item.gouraud_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.command_kind(command_kind), .jump_kind(jump_kind), .end_flag(end_flag),
		.color_mode_code(color_mode_code), .color_calc(color_calc), .draw_flags(draw_flags),
		.pattern_addr(pattern_addr), .pattern_width(pattern_width),
		.pattern_height(pattern_height),
		.shade_addr(shade_addr), .next_offset(next_offset), .walk_stop(walk_stop)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// walker shadow state
	logic [18:0] cfg_start = '0;
	logic [15:0] cfg_limit = 16'hFFFF;
	logic [18:0] walk_offset = '0;
	logic [18:0] ret_stack [CALL_DEPTH];
	int unsigned ret_depth = 0;
	logic [15:0] walk_count = '0;
	bit          walk_on = 1'b0;
	logic [15:0] user_rect [4];
	logic [15:0] sys_rect [4];
	logic [15:0] origin_xy [2];

	cmd_t pending_items [$];
	res_t expected_results [$];

	int error_count = 0;
	int accepted_items = 0;
	int checked_results = 0;
	int walks_started = 0;
	int walk_stops = 0;
	int config_writes = 0;

	task automatic add_pending(input cmd_t c);
		pending_items = {pending_items, c};
	endtask

	task automatic add_expected(input res_t r);
		expected_results = {expected_results, r};
	endtask

	task automatic predict_walk_step(input cmd_t c);
		res_t r;
		logic [3:0] k;
		logic [2:0] jm;
		logic [18:0] nxt;
		logic [15:0] md;
		r = '0;
		if (c.operation == OP_START) begin
			walk_offset = cfg_start;
			ret_depth = 0;
			walk_count = '0;
			walk_on = 1'b1;
			walks_started++;
			return;
		end
		if (!walk_on)
			return;
		r.next_offset = walk_offset;
		r.walk_stop = 1'b1;
		if (int'(walk_offset) + CMD_STRIDE > VRAM_BYTES) begin
			r.command_kind = KIND_INVALID;
			walk_on = 1'b0;
			walk_stops++;
			add_expected(r);
			return;
		end
		md = c.mode_word;
		k = KIND_MAP[{c.ctrl_word[3:0], 2'b00} +: 4];
		jm = c.ctrl_word[10:8];
		if (jm > JMP_SKIP)
			jm = JMP_INVALID;
		r.command_kind = k;
		r.jump_kind = jm;
		r.end_flag = c.ctrl_word[15];
		r.color_mode_code = (md[5:3] > CMODE_RGB) ? CMODE_INVALID : md[5:3];
		r.color_calc = md[8:6];
		r.draw_flags = {md[7], md[8], md[10], md[0]};
		r.pattern_addr = {c.source_word, 3'b000};
		r.pattern_width = {c.size_word[13:8], 3'b000};
		r.pattern_height = c.size_word[7:0];
		r.shade_addr = {c.gouraud_word, 3'b000};
		if (k == KIND_INVALID) begin
			walk_on = 1'b0;
			walk_stops++;
			add_expected(r);
			return;
		end
		case (k)
			KIND_USER_CLIP: user_rect = '{c.vertex_a_x, c.vertex_a_y, c.vertex_c_x, c.vertex_c_y};
			KIND_SYS_CLIP:  sys_rect = '{c.vertex_a_x, c.vertex_a_y, c.vertex_c_x, c.vertex_c_y};
			KIND_LOCAL:     origin_xy = '{c.vertex_a_x, c.vertex_a_y};
			default: ;
		endcase
		walk_count++;
		if (c.ctrl_word[15]) begin
			walk_on = 1'b0;
			walk_stops++;
			add_expected(r);
			return;
		end
		nxt = walk_offset + 19'(CMD_STRIDE);
		case (jm)
			JMP_ASSIGN: nxt = {c.link_word, 3'b000};
			JMP_CALL: begin
				if (ret_depth < CALL_DEPTH) begin
					ret_stack[ret_depth] = nxt;
					ret_depth++;
				end
				nxt = {c.link_word, 3'b000};
			end
			JMP_RETURN: begin
				if (ret_depth > 0) begin
					ret_depth--;
					nxt = ret_stack[ret_depth];
				end
			end
			JMP_SKIP: nxt = walk_offset + 19'(2 * CMD_STRIDE);
			default: ;
		endcase
		walk_offset = nxt;
		r.next_offset = nxt;
		r.walk_stop = (walk_count >= cfg_limit);
		if (r.walk_stop) begin
			walk_on = 1'b0;
			walk_stops++;
		end
		add_expected(r);
	endtask

	// sender: bursts with gaps
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_walk_step(in_item);
				accepted_items++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					in_item <= pending_items.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 150 : 12);
						gap_left = $urandom_range(0, 5);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want_v, got_v);
		if (want_v !== got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
			error_count++;
		end
	endtask

	// receiver: checks results, stalls on its own pattern
	stall_mode_e stall_mode = STALL_NONE;
	int stall_left = 0;
	int cycle_count = 0;
	res_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					error_count++;
				end else begin
					want = expected_results.pop_front();
					checked_results++;
					check_field("command_kind", 32'(want.command_kind), 32'(command_kind));
					check_field("jump_kind", 32'(want.jump_kind), 32'(jump_kind));
					check_field("end_flag", 32'(want.end_flag), 32'(end_flag));
					check_field("color_mode_code", 32'(want.color_mode_code),
						32'(color_mode_code));
					check_field("color_calc", 32'(want.color_calc), 32'(color_calc));
					check_field("draw_flags", 32'(want.draw_flags), 32'(draw_flags));
					check_field("pattern_addr", 32'(want.pattern_addr), 32'(pattern_addr));
					check_field("pattern_width", 32'(want.pattern_width), 32'(pattern_width));
					check_field("pattern_height", 32'(want.pattern_height),
						32'(pattern_height));
					check_field("shade_addr", 32'(want.shade_addr), 32'(shade_addr));
					check_field("next_offset", 32'(want.next_offset), 32'(next_offset));
					check_field("walk_stop", 32'(want.walk_stop), 32'(walk_stop));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
			end else begin
				stall_mode = stall_mode_e'($urandom_range(0, 3));
				stall_left = $urandom_range(64, 400);
			end
			case (stall_mode)
				STALL_NONE:     out_stall <= 1'b0;
				STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
				STALL_PERIODIC: out_stall <= ((cycle_count % 7) < 3);
				default:        out_stall <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		config_writes++;
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		// a trailing start transaction may still sit in the pipe
		repeat (4) @(posedge clk);
	endtask

	task automatic set_walk_config(input logic [18:0] so, input logic [15:0] lim);
		drain();
		apb_write(REG_START_OFFSET, 32'(so));
		cfg_start = so;
		apb_write(REG_COMMAND_LIMIT, 32'(lim));
		cfg_limit = lim;
	endtask

	function automatic cmd_t random_fields();
		cmd_t c;
		c.operation = 1'($urandom);
		c.ctrl_word = 16'($urandom);
		c.link_word = 16'($urandom);
		c.mode_word = 16'($urandom);
		c.source_word = 16'($urandom);
		c.size_word = 16'($urandom);
		c.vertex_a_x = 16'($urandom);
		c.vertex_a_y = 16'($urandom);
		c.vertex_c_x = 16'($urandom);
		c.vertex_c_y = 16'($urandom);
		c.gouraud_word = 16'($urandom);
		return c;
	endfunction

	function automatic cmd_t start_item();
		cmd_t c;
		c = random_fields();
		c.operation = OP_START;
		return c;
	endfunction

	function automatic logic [15:0] ctrl_of(input bit endb, input logic [2:0] jm,
			input logic [3:0] code);
		return {endb, 4'($urandom), jm, 4'($urandom), code};
	endfunction

	function automatic cmd_t cmd_item(input logic [15:0] ctrl, link, mode);
		cmd_t c;
		c = random_fields();
		c.operation = OP_CMD;
		c.ctrl_word = ctrl;
		c.link_word = link;
		c.mode_word = mode;
		return c;
	endfunction

	function automatic cmd_t random_command(input bit last);
		cmd_t c;
		logic [3:0] code;
		logic [2:0] jm;
		int idx;
		int r;
		bit endb;
		c = random_fields();
		c.operation = OP_CMD;
		idx = $urandom_range(0, 8);
		code = ($urandom_range(0, 19) == 0) ? 4'($urandom) : VALID_CODES[4 * idx +: 4];
		r = $urandom_range(0, 99);
		if (r < 30)
			jm = JMP_NEXT;
		else if (r < 45)
			jm = JMP_ASSIGN;
		else if (r < 65)
			jm = JMP_CALL;
		else if (r < 85)
			jm = JMP_RETURN;
		else if (r < 95)
			jm = JMP_SKIP;
		else
			jm = 3'($urandom_range(JMP_INVALID, 7));
		endb = last ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 59) == 0);
		c.ctrl_word = ctrl_of(endb, jm, code);
		if ($urandom_range(0, 32) == 0)
			c.link_word = 16'($urandom_range(65533, 65535));
		return c;
	endfunction

	task automatic queue_random_walks(input int n);
		int made;
		int len;
		cmd_t c;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 9) == 0) begin
				c = random_fields();
				add_pending(c);
				made++;
			end else begin
				add_pending(start_item());
				len = $urandom_range(1, 24);
				for (int j = 0; j < len; j++)
					add_pending(random_command(j == len - 1));
				made += len + 1;
			end
		end
	endtask

	task automatic queue_directed();
		cmd_t c;
		// command with no walk active
		add_pending(cmd_item(ctrl_of(1'b0, JMP_NEXT, CODE_NORMAL), 16'($urandom),
			16'($urandom)));
		add_pending(start_item());
		c.operation = OP_CMD;
		c.ctrl_word = ctrl_of(1'b0, JMP_NEXT, CODE_NORMAL);
		c.link_word = 16'hFFFF;
		c.mode_word = 16'hFFFF;
		c.source_word = 16'hFFFF;
		c.size_word = 16'hFFFF;
		c.vertex_a_x = 16'sh8000;
		c.vertex_a_y = 16'sh7FFF;
		c.vertex_c_x = 16'sh7FFF;
		c.vertex_c_y = 16'sh8000;
		c.gouraud_word = 16'hFFFF;
		add_pending(c);
		c = '0;
		c.operation = OP_CMD;
		add_pending(c);
		// five calls against a four-deep stack, then returns; walks all color modes
		for (int i = 0; i < 8; i++)
			add_pending(cmd_item(ctrl_of(1'b0, (i < 5) ? JMP_CALL : JMP_RETURN,
				VALID_CODES[4 * (i + 1) +: 4]), 16'(i + 1) << 8, 16'(i) << 3));
		add_pending(cmd_item(ctrl_of(1'b0, JMP_RETURN, CODE_NORMAL), '0, MODE_ECD));
		add_pending(cmd_item(ctrl_of(1'b0, JMP_RETURN, CODE_NORMAL), '0, MODE_SPD));
		add_pending(cmd_item(ctrl_of(1'b0, JMP_SKIP, CODE_NORMAL), '0, MODE_GOURAUD));
		for (int k = 0; k < 3; k++)
			add_pending(cmd_item(ctrl_of(1'b0, JMP_INVALID + 3'(k), CODE_NORMAL), '0,
				MODE_MESH));
		// jump to an offset whose command would run past the end of memory, then fetch there
		add_pending(cmd_item(ctrl_of(1'b0, JMP_ASSIGN, CODE_NORMAL), 16'hFFFF, '0));
		add_pending(cmd_item(ctrl_of(1'b0, JMP_NEXT, CODE_NORMAL), '0, '0));
		add_pending(cmd_item(ctrl_of(1'b0, JMP_NEXT, CODE_NORMAL), '0, '0));
		add_pending(start_item());
		add_pending(cmd_item(ctrl_of(1'b0, JMP_NEXT, CODE_BAD), 16'($urandom),
			16'($urandom)));
		add_pending(start_item());
		add_pending(cmd_item(ctrl_of(1'b1, JMP_CALL, CODE_USER_CLIP), 16'h0040,
			16'($urandom)));
		add_pending(start_item());
		add_pending(cmd_item(ctrl_of(1'b0, JMP_NEXT, CODE_BAD_TOP), 16'($urandom),
			16'($urandom)));
	endtask

	initial begin
		#(5_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		user_rect = '{16'd0, 16'd0, CLIP_MAX_X, CLIP_MAX_Y};
		sys_rect = '{16'd0, 16'd0, CLIP_MAX_X, CLIP_MAX_Y};
		origin_xy = '{16'd0, 16'd0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_walk_config(19'd0, 16'hFFFF);
		queue_directed();

		// start just below the top: wrap on next and skip, limit of one
		set_walk_config(19'h7FFE0, 16'd1);
		add_pending(start_item());
		add_pending(cmd_item(ctrl_of(1'b0, JMP_NEXT, CODE_NORMAL), '0, '0));
		add_pending(cmd_item(ctrl_of(1'b0, JMP_NEXT, CODE_NORMAL), '0, '0));
		add_pending(start_item());
		add_pending(cmd_item(ctrl_of(1'b0, JMP_SKIP, CODE_SCALED), '0, '0));

		set_walk_config(19'h7FFFF, 16'd2);
		add_pending(start_item());
		add_pending(cmd_item(ctrl_of(1'b0, JMP_NEXT, CODE_NORMAL), '0, '0));
		add_pending(start_item());
		add_pending(cmd_item(ctrl_of(1'b0, JMP_CALL, CODE_LOCAL), '0, '0));

		set_walk_config(19'($urandom), 16'hFFFF);
		queue_random_walks(400);
		set_walk_config(19'($urandom) & ~19'h1F, 16'd1);
		queue_random_walks(150);
		set_walk_config(19'd0, 16'($urandom_range(2, 12)));
		queue_random_walks(300);
		set_walk_config(19'($urandom), 16'($urandom_range(1, 65535)));
		queue_random_walks(300);
		set_walk_config(19'h7FFE0, 16'hFFFF);
		queue_random_walks(200);
		set_walk_config(19'($urandom), 16'hFFFF);
		queue_random_walks(400);
		drain();

		$display("Walker run: %0d input transactions, %0d walks started, %0d walk stops",
			accepted_items, walks_started, walk_stops);
		$display("Results checked: %0d, register writes: %0d, mismatches: %0d",
			checked_results, config_writes, error_count);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
rtl/scwl_pkg.sv
rtl/scwl_decode.sv
rtl/scwl_walker.sv
rtl/sprite_command_list_walker.sv
dv/tb_sprite_command_list_walker.sv
